// ----- src/kthr_pkg.sv -----
// ----------------------------------------------------------------------------
// kthr_pkg
// Shared constants and control types for the k-th neighbour radius block.
// ----------------------------------------------------------------------------
package kthr_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_RANK_DEF   = 8;
  localparam int COORD_BITS_DEF = 24;

  localparam int RADIUS_W = 25;
  localparam int RANK_W   = 4;
  localparam int INFL_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};
  localparam logic [RANK_W-1:0]   RANK_RESET = RANK_W'(3);
  localparam logic [INFL_W-1:0]   INFL_RESET = INFL_W'(33423);

  localparam logic [CFG_IDX_W-1:0] REG_RANK    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INFLATE = CFG_IDX_W'(1);

  typedef struct packed {
    logic store;
    logic query_cap;
    logic list_clr;
    logic diff;
    logic square;
    logic insert;
    logic sqrt_init;
    logic sqrt_step;
    logic scale;
    logic round;
    logic last;
  } cmd_t;

endpackage

// ----- src/kthr_point_if.sv -----
// ----------------------------------------------------------------------------
// kthr_point_if
// Input channel carrying one point word per handshake.
// ----------------------------------------------------------------------------
interface kthr_point_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         set_end;

  modport source (output valid, coord_x, coord_y, coord_z, set_end, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, set_end, output ready);
endinterface

// ----- src/kthr_radius_if.sv -----
// ----------------------------------------------------------------------------
// kthr_radius_if
// Output channel carrying one radius word per handshake.
// ----------------------------------------------------------------------------
interface kthr_radius_if;
  import kthr_pkg::*;
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] radius;
  logic                shortage;
  logic                run_end;

  modport source (output valid, radius, shortage, run_end, input ready);
  modport sink   (input valid, radius, shortage, run_end, output ready);
endinterface

// ----- src/kth_neighbour_radius.sv -----
// ----------------------------------------------------------------------------
// kth_neighbour_radius
// Loads a set of 3D points and emits, per point, the scaled distance to its
// k-th nearest distinct neighbour.
// ----------------------------------------------------------------------------
// Channel   Dir  Word
// pt_in     in   coord_x, coord_y, coord_z, set_end
// rad_out   out  radius, shortage, run_end
// cfg       in   cfg_we, cfg_index, cfg_data (rank, inflate)
//
// Point words are taken while idle; the word marked set_end starts the search.
// Each result comes from a scan of the N stored points, each read, differenced,
// squared and inserted in turn, followed by the bit-pair square root and scale.
// Reset clears the point count and restores rank 3 and inflate 33423.
// No input word is taken from set_end until the last result has been taken.
// ----------------------------------------------------------------------------
module kth_neighbour_radius
  import kthr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_RANK   = MAX_RANK_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  kthr_point_if.sink            pt_in,
  kthr_radius_if.source         rad_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  cmd_t          cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  kthr_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pt_in.valid),
    .in_set_end(pt_in.set_end),
    .in_ready  (pt_in.ready),
    .out_valid (rad_out.valid),
    .out_ready (rad_out.ready),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  kthr_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_RANK  (MAX_RANK),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .in_x     (pt_in.coord_x),
    .in_y     (pt_in.coord_y),
    .in_z     (pt_in.coord_z),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .radius   (rad_out.radius),
    .shortage (rad_out.shortage),
    .run_end  (rad_out.run_end)
  );

`ifndef ASSERT_OFF
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    rad_out.valid |-> !pt_in.ready)
    else $error("input open while a result is pending");

  a_end_closes_in: assert property (@(posedge clk) disable iff (rst)
    (pt_in.valid && pt_in.ready && pt_in.set_end) |=> !pt_in.ready)
    else $error("input still open after the final point");

  a_run_end_reopens: assert property (@(posedge clk) disable iff (rst)
    (rad_out.valid && rad_out.ready && rad_out.run_end) |=> pt_in.ready)
    else $error("input not reopened after the final result");
`endif

endmodule

// ----- src/kthr_datapath.sv -----
// ----------------------------------------------------------------------------
// kthr_datapath
// Point memory, distance pipeline, sorted nearest list, square root and scale.
// ----------------------------------------------------------------------------
module kthr_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_RANK   = 8,
  parameter int COORD_BITS = 24,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kthr_pkg::cmd_t                   cmd,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [AW-1:0]                    rd_addr,
  input  logic signed [COORD_BITS-1:0]     in_x,
  input  logic signed [COORD_BITS-1:0]     in_y,
  input  logic signed [COORD_BITS-1:0]     in_z,
  input  logic                             cfg_we,
  input  logic [kthr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kthr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [kthr_pkg::RADIUS_W-1:0]    radius,
  output logic                             shortage,
  output logic                             run_end
);
  import kthr_pkg::*;

  localparam int PW  = 3 * COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int D2W = SQW + 2;
  localparam int FW  = $clog2(MAX_RANK + 1);
  localparam int RW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int PRW = RADIUS_W + INFL_W;

  logic [PW-1:0] mem [MAX_POINTS];
  logic [PW-1:0] rdata;
  logic [PW-1:0] qpt;

  logic [RANK_W-1:0] rank;
  logic [INFL_W-1:0] inflate;
  logic [FW-1:0]     k;

  logic [DW-1:0]  ax, ay, az;
  logic           same;
  logic [SQW-1:0] sx, sy, sz;
  logic           same_d;
  logic [D2W-1:0] d2;

  logic [D2W-1:0] lst [MAX_RANK];
  logic [D2W-1:0] lst_next [MAX_RANK];
  logic [MAX_RANK-1:0] lt;
  logic [FW-1:0]  cnt;
  logic [FW-1:0]  cnt_m1;

  logic [D2W-1:0] sq_n, sq_r, sq_bit, sq_sum;
  logic [RADIUS_W-1:0] root;
  logic [PRW-1:0] prod;
  logic [PRW:0]   rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank    <= RANK_RESET;
      inflate <= INFL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_RANK) begin
        rank <= cfg_data[RANK_W-1:0];
      end
      if (cfg_index == REG_INFLATE) begin
        inflate <= cfg_data[INFL_W-1:0];
      end
    end
  end

  always_comb begin
    if (rank == '0) begin
      k = FW'(1);
    end else if (int'(rank) > MAX_RANK) begin
      k = FW'(MAX_RANK);
    end else begin
      k = FW'(rank);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wr_addr] <= {in_x, in_y, in_z};
    end
    rdata <= mem[rd_addr];
    if (cmd.query_cap) begin
      qpt <= rdata;
    end
  end

  function automatic logic [DW-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                             input logic [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(signed'(a)) - DW'(signed'(b));
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      ax   <= abs_diff(rdata[3*COORD_BITS-1:2*COORD_BITS], qpt[3*COORD_BITS-1:2*COORD_BITS]);
      ay   <= abs_diff(rdata[2*COORD_BITS-1:COORD_BITS], qpt[2*COORD_BITS-1:COORD_BITS]);
      az   <= abs_diff(rdata[COORD_BITS-1:0], qpt[COORD_BITS-1:0]);
      same <= (rdata == qpt);
    end
    if (cmd.square) begin
      sx     <= ax * ax;
      sy     <= ay * ay;
      sz     <= az * az;
      same_d <= same;
    end
  end

  assign d2 = D2W'(sx) + D2W'(sy) + D2W'(sz);

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_ins
    assign lt[i] = d2 < lst[i];
    if (i == 0) begin : g_first
      assign lst_next[i] = lt[i] ? d2 : lst[i];
    end else begin : g_rest
      assign lst_next[i] = lt[i] ? (lt[i-1] ? lst[i-1] : d2) : lst[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.list_clr) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        lst[i] <= '1;
      end
      cnt <= '0;
    end else if (cmd.insert && !same_d) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        lst[i] <= lst_next[i];
      end
      if (cnt < k) begin
        cnt <= cnt + FW'(1);
      end
    end
  end

  assign cnt_m1 = cnt - FW'(1);
  assign sq_sum = sq_r + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_n     <= (cnt == '0) ? '0 : lst[cnt_m1[RW-1:0]];
      sq_r     <= '0;
      sq_bit   <= D2W'(1) << (D2W - 2);
      shortage <= cnt < k;
    end else if (cmd.sqrt_step) begin
      if (sq_n >= sq_sum) begin
        sq_n <= sq_n - sq_sum;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  assign root = (sq_r > D2W'(RADIUS_MAX)) ? RADIUS_MAX : sq_r[RADIUS_W-1:0];
  assign rounded = (PRW+1)'(prod) + (PRW+1)'(32768);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod <= root * inflate;
    end
    if (cmd.round) begin
      radius  <= (rounded[PRW:16] > (PRW-15)'(RADIUS_MAX)) ? RADIUS_MAX
                                                          : rounded[RADIUS_W+15:16];
      run_end <= cmd.last;
    end
  end

endmodule

// ----- src/kthr_ctrl.sv -----
// ----------------------------------------------------------------------------
// kthr_ctrl
// Sequencer for loading points and running one neighbour search per point.
// ----------------------------------------------------------------------------
module kthr_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_set_end,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output kthr_pkg::cmd_t cmd,
  output logic [AW-1:0]  wr_addr,
  output logic [AW-1:0]  rd_addr
);
  import kthr_pkg::*;

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int D2W   = 2 * (COORD_BITS + 1) + 2;
  localparam int ITER  = D2W / 2;
  localparam int IW    = $clog2(ITER + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_QRD   = 10'b0000000010,
    S_QCAP  = 10'b0000000100,
    S_JDIF  = 10'b0000001000,
    S_JSQ   = 10'b0000010000,
    S_JINS  = 10'b0000100000,
    S_SQRT  = 10'b0001000000,
    S_SCALE = 10'b0010000000,
    S_RND   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] q, q_next;
  logic [CW-1:0] j, j_next;
  logic [IW-1:0] iter, iter_next;
  logic          last_q;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign wr_addr   = count[AW-1:0];
  assign last_q    = (q + CW'(1) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      q     <= '0;
      j     <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      q     <= q_next;
      j     <= j_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    q_next     = q;
    j_next     = j;
    iter_next  = iter;
    cmd        = '0;
    cmd.last   = last_q;
    rd_addr    = q[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (int'(count) < MAX_POINTS) begin
            cmd.store  = 1'b1;
            count_next = count + CW'(1);
          end
          if (in_set_end) begin
            q_next     = '0;
            state_next = S_QRD;
          end
        end
      end
      S_QRD: begin
        state_next = S_QCAP;
      end
      S_QCAP: begin
        cmd.query_cap = 1'b1;
        cmd.list_clr  = 1'b1;
        rd_addr       = '0;
        j_next        = '0;
        state_next    = S_JDIF;
      end
      S_JDIF: begin
        cmd.diff   = 1'b1;
        state_next = S_JSQ;
      end
      S_JSQ: begin
        cmd.square = 1'b1;
        state_next = S_JINS;
      end
      S_JINS: begin
        cmd.insert = 1'b1;
        j_next     = j + CW'(1);
        rd_addr    = j_next[AW-1:0];
        if (j_next == count) begin
          state_next = S_SQRT;
          iter_next  = '0;
          cmd.sqrt_init = 1'b0;
        end else begin
          state_next = S_JDIF;
        end
      end
      S_SQRT: begin
        if (iter == '0) begin
          cmd.sqrt_init = 1'b1;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
        iter_next = iter + IW'(1);
        if (iter == IW'(ITER)) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.round  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_q) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            q_next     = q + CW'(1);
            state_next = S_QRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
